// ===== rtl/core/spc_pkg.sv =====
`default_nettype none
package spc_pkg;

   localparam int CAPTURE_WIDTH = 16;

   localparam int SUM_W      = 20;
   localparam int SUM_CALC_W = ((CAPTURE_WIDTH > SUM_W) ? CAPTURE_WIDTH : SUM_W) + 1;
   localparam int PHASE_W    = 4;
   localparam int STALL_W    = 10;
   localparam int SPEED_W    = 16;
   localparam int SETPT_W    = 16;
   localparam int ERR_W      = 17;
   localparam int INTEG_W    = 18;
   localparam int CLAMP_W    = INTEG_W + 1;
   localparam int LIMIT_W    = 16;
   localparam int GAIN_W     = 24;
   localparam int WORD_W     = 32;
   localparam int PROD_W     = INTEG_W + GAIN_W;
   localparam int DRIVE_W    = PROD_W + 2;
   localparam int DUTY_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int DIV_CNT_W  = $clog2(WORD_W);
   localparam int MUL_CNT_W  = $clog2(GAIN_W);

   localparam logic [GAIN_W-1:0]  RST_P_GAIN           = GAIN_W'(39063);
   localparam logic [GAIN_W-1:0]  RST_I_GAIN           = GAIN_W'(3906);
   localparam logic [WORD_W-1:0]  RST_DRIVE_OFFSET     = WORD_W'(20000000);
   localparam logic [LIMIT_W-1:0] RST_INTEGRAL_LIMIT   = LIMIT_W'(38400);
   localparam logic [STALL_W-1:0] RST_STALL_TICKS      = STALL_W'(300);
   localparam logic [SETPT_W-1:0] RST_MIN_SETPOINT     = SETPT_W'(256);
   localparam logic [PHASE_W-1:0] RST_EDGES_PER_SAMPLE = PHASE_W'(3);
   localparam logic [WORD_W-1:0]  RST_RATE_NUMERATOR   = WORD_W'(25600000);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_ERR,
      ST_MUL,
      ST_SUM,
      ST_FINAL
   } state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_P_GAIN           = 3'd0,
      CSR_I_GAIN           = 3'd1,
      CSR_DRIVE_OFFSET     = 3'd2,
      CSR_INTEGRAL_LIMIT   = 3'd3,
      CSR_STALL_TICKS      = 3'd4,
      CSR_MIN_SETPOINT     = 3'd5,
      CSR_EDGES_PER_SAMPLE = 3'd6,
      CSR_RATE_NUMERATOR   = 3'd7
   } csr_index_type;

endpackage
`default_nettype wire

// ===== rtl/core/spc_if.sv =====
`default_nettype none
interface spc_req_if;
   logic                               valid;
   logic                               ready;
   logic                               action;
   logic [spc_pkg::CAPTURE_WIDTH-1:0]  capture_time;
   logic [spc_pkg::SETPT_W-1:0]        setpoint;
   modport source (output valid, action, capture_time, setpoint, input ready);
   modport sink (input valid, action, capture_time, setpoint, output ready);
endinterface

interface spc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [spc_pkg::DUTY_W-1:0]         duty;
   logic [spc_pkg::SPEED_W-1:0]        speed;
   logic signed [spc_pkg::ERR_W-1:0]   error;
   modport source (output valid, duty, speed, error, input ready);
   modport sink (input valid, duty, speed, error, output ready);
endinterface

interface spc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [spc_pkg::CSR_IDX_W-1:0]      index;
   logic [spc_pkg::WORD_W-1:0]         data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/spc_edge.sv =====
`default_nettype none
module spc_edge (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              edge_fire,
   input  wire logic [spc_pkg::CAPTURE_WIDTH-1:0] capture_time,
   input  wire logic                              seen_clear,
   input  wire logic [spc_pkg::PHASE_W-1:0]       edges_per_sample,
   output logic      [spc_pkg::SUM_W-1:0]         rev_period,
   output logic                                   edge_seen
);

   logic [spc_pkg::CAPTURE_WIDTH-1:0] last_capture_ff, last_capture_in;
   logic [spc_pkg::SUM_W-1:0]         period_sum_ff, period_sum_in;
   logic [spc_pkg::PHASE_W-1:0]       edge_phase_ff, edge_phase_in;
   logic [spc_pkg::SUM_W-1:0]         rev_period_ff, rev_period_in;
   logic                              edge_seen_ff, edge_seen_in;

   logic [spc_pkg::CAPTURE_WIDTH-1:0] period;
   logic [spc_pkg::SUM_CALC_W-1:0]    sum;
   logic [spc_pkg::SUM_W-1:0]         sum_sat;
   logic [spc_pkg::PHASE_W-1:0]       phase_next;

   always_comb begin
      // timer wraps, so the difference is taken modulo the capture width
      period     = capture_time - last_capture_ff;
      sum        = spc_pkg::SUM_CALC_W'(period_sum_ff) + spc_pkg::SUM_CALC_W'(period);
      sum_sat    = (sum[spc_pkg::SUM_CALC_W-1:spc_pkg::SUM_W] != '0) ? '1
                                                                  : sum[spc_pkg::SUM_W-1:0];
      phase_next = edge_phase_ff + spc_pkg::PHASE_W'(1);

      last_capture_in = last_capture_ff;
      period_sum_in   = period_sum_ff;
      edge_phase_in   = edge_phase_ff;
      rev_period_in   = rev_period_ff;
      edge_seen_in    = edge_seen_ff;

      if (seen_clear) begin
         edge_seen_in = 1'b0;
      end
      if (edge_fire) begin
         last_capture_in = capture_time;
         edge_seen_in    = 1'b1;
         if (phase_next >= edges_per_sample) begin
            rev_period_in = sum_sat;
            period_sum_in = '0;
            edge_phase_in = '0;
         end else begin
            period_sum_in = sum_sat;
            edge_phase_in = phase_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_capture_ff <= '0;
         period_sum_ff   <= '0;
         edge_phase_ff   <= '0;
         rev_period_ff   <= '0;
         edge_seen_ff    <= 1'b0;
      end else begin
         last_capture_ff <= last_capture_in;
         period_sum_ff   <= period_sum_in;
         edge_phase_ff   <= edge_phase_in;
         rev_period_ff   <= rev_period_in;
         edge_seen_ff    <= edge_seen_in;
      end
   end

   assign rev_period = rev_period_ff;
   assign edge_seen  = edge_seen_ff;

endmodule
`default_nettype wire

// ===== rtl/core/spc_div.sv =====
`default_nettype none
module spc_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [spc_pkg::WORD_W-1:0] dividend,
   input  wire logic [spc_pkg::SUM_W-1:0]  divisor,
   output logic                            done,
   output logic      [spc_pkg::WORD_W-1:0] quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [spc_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [spc_pkg::SUM_W-1:0]         rem_ff, rem_in;
   logic [spc_pkg::SUM_W-1:0]         dvs_ff, dvs_in;
   logic [spc_pkg::WORD_W-1:0]        quo_ff, quo_in;

   logic [spc_pkg::SUM_W:0]           shifted;
   logic [spc_pkg::SUM_W+1:0]         diff;

   always_comb begin
      // restoring divide, one quotient bit per cycle, dividend shifts out as quotient shifts in
      shifted = {rem_ff, quo_ff[spc_pkg::WORD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!diff[spc_pkg::SUM_W+1]) begin
            rem_in = diff[spc_pkg::SUM_W-1:0];
            quo_in = {quo_ff[spc_pkg::WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[spc_pkg::SUM_W-1:0];
            quo_in = {quo_ff[spc_pkg::WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + spc_pkg::DIV_CNT_W'(1);
         if (cnt_ff == spc_pkg::DIV_CNT_W'(spc_pkg::WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== rtl/core/spc_mult.sv =====
`default_nettype none
module spc_mult (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [spc_pkg::INTEG_W-1:0] mcand,
   input  wire logic        [spc_pkg::GAIN_W-1:0]  gain,
   output logic                                    done,
   output logic signed      [spc_pkg::PROD_W-1:0]  product
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [spc_pkg::MUL_CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [spc_pkg::INTEG_W-1:0]   mcand_ff, mcand_in;
   logic [spc_pkg::GAIN_W-1:0]           gain_ff, gain_in;
   logic signed [spc_pkg::PROD_W-1:0]    acc_ff, acc_in;

   logic signed [spc_pkg::PROD_W-1:0]    addend;

   always_comb begin
      // msb-first shift and add over the unsigned gain bits
      addend = gain_ff[spc_pkg::GAIN_W-1] ? spc_pkg::PROD_W'(mcand_ff) : '0;

      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      gain_in  = gain_ff;
      acc_in   = acc_ff;

      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = mcand;
         gain_in  = gain;
         acc_in   = '0;
      end else if (busy_ff) begin
         acc_in  = (acc_ff <<< 1) + addend;
         gain_in = {gain_ff[spc_pkg::GAIN_W-2:0], 1'b0};
         cnt_in  = cnt_ff + spc_pkg::MUL_CNT_W'(1);
         if (cnt_ff == spc_pkg::MUL_CNT_W'(spc_pkg::GAIN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff <= mcand_in;
      gain_ff  <= gain_in;
      acc_ff   <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
`default_nettype wire

// ===== rtl/core/encoder_speed_pi_controller.sv =====
`default_nettype none
// Speed PI controller for one wheel. An edge beat (action 0) records the encoder capture time
// and is taken in the idle state; it gives no response. A tick beat (action 1) gives one response
// beat with duty, speed and error. A tick after edges with a nonzero revolution period runs a
// bit-serial divide for the speed, then two bit-serial multiplies for the proportional and
// integral terms run side by side. A tick passes through the divide, error, multiply, sum and
// final states in that order, and one without the divide skips the divide state; the final
// state waits until the response register is free. One item is in work at a time; a finished
// response waits in its own register while the next item is taken. Configuration writes
// belong to idle periods.
module encoder_speed_pi_controller (
   input wire logic clock,
   input wire logic reset,
   spc_req_if.sink   req_ch,
   spc_rsp_if.source rsp_ch,
   spc_csr_if.sink   csr_ch
);

   // configuration
   logic [spc_pkg::GAIN_W-1:0]  p_gain_ff;
   logic [spc_pkg::GAIN_W-1:0]  i_gain_ff;
   logic [spc_pkg::WORD_W-1:0]  drive_offset_ff;
   logic [spc_pkg::LIMIT_W-1:0] integral_limit_ff;
   logic [spc_pkg::STALL_W-1:0] stall_ticks_ff;
   logic [spc_pkg::SETPT_W-1:0] min_setpoint_ff;
   logic [spc_pkg::PHASE_W-1:0] edges_per_sample_ff;
   logic [spc_pkg::WORD_W-1:0]  rate_numerator_ff;

   spc_pkg::state_type                 state_ff, state_in;
   logic [spc_pkg::SETPT_W-1:0]        setpoint_ff, setpoint_in;
   logic [spc_pkg::SPEED_W-1:0]        speed_ff, speed_in;
   logic signed [spc_pkg::INTEG_W-1:0] integral_ff, integral_in;
   logic [spc_pkg::STALL_W-1:0]        stall_ff, stall_in;
   logic signed [spc_pkg::ERR_W-1:0]   err_ff, err_in;
   logic signed [spc_pkg::DRIVE_W-1:0] drive_ff, drive_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [spc_pkg::DUTY_W-1:0]         rsp_duty_ff, rsp_duty_in;
   logic [spc_pkg::SPEED_W-1:0]        rsp_speed_ff, rsp_speed_in;
   logic signed [spc_pkg::ERR_W-1:0]   rsp_error_ff, rsp_error_in;

   logic                               req_fire;
   logic                               edge_fire;
   logic                               seen_clear;
   logic [spc_pkg::SUM_W-1:0]          rev_period;
   logic                               edge_seen;
   logic                               div_start;
   logic                               div_done;
   logic [spc_pkg::WORD_W-1:0]         quotient;
   logic                               mul_start;
   logic                               p_done;
   logic                               i_done;
   logic signed [spc_pkg::PROD_W-1:0]  p_prod;
   logic signed [spc_pkg::PROD_W-1:0]  i_prod;

   logic [spc_pkg::STALL_W-1:0]        stall_inc;
   logic signed [spc_pkg::ERR_W-1:0]   err_now;
   logic signed [spc_pkg::CLAMP_W-1:0] acc;
   logic signed [spc_pkg::CLAMP_W-1:0] lim_pos;
   logic signed [spc_pkg::CLAMP_W-1:0] lim_neg;
   logic signed [spc_pkg::CLAMP_W-1:0] acc_cl;
   logic signed [spc_pkg::INTEG_W-1:0] p_mcand;
   logic signed [spc_pkg::DRIVE_W-1:0] drive_sum;
   logic [spc_pkg::WORD_W-1:0]         drive_sat;

   assign req_ch.ready = (state_ff == spc_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign edge_fire    = req_fire && !req_ch.action;
   assign csr_ch.ready = 1'b1;

   spc_edge u_edge (
      .clock            (clock),
      .reset            (reset),
      .edge_fire        (edge_fire),
      .capture_time     (req_ch.capture_time),
      .seen_clear       (seen_clear),
      .edges_per_sample (edges_per_sample_ff),
      .rev_period       (rev_period),
      .edge_seen        (edge_seen)
   );

   spc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rate_numerator_ff),
      .divisor  (rev_period),
      .done     (div_done),
      .quotient (quotient)
   );

   spc_mult u_p_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (p_mcand),
      .gain    (p_gain_ff),
      .done    (p_done),
      .product (p_prod)
   );

   spc_mult u_i_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (acc_cl[spc_pkg::INTEG_W-1:0]),
      .gain    (i_gain_ff),
      .done    (i_done),
      .product (i_prod)
   );

   always_comb begin
      stall_inc = (stall_ff == '1) ? stall_ff : stall_ff + spc_pkg::STALL_W'(1);
      err_now   = $signed({1'b0, speed_ff}) - $signed({1'b0, setpoint_ff});
      acc       = spc_pkg::CLAMP_W'(integral_ff) + spc_pkg::CLAMP_W'(err_now);
      lim_pos   = $signed(spc_pkg::CLAMP_W'(integral_limit_ff));
      lim_neg   = -lim_pos;
      acc_cl    = acc;
      if (acc < lim_neg) begin
         acc_cl = lim_neg;
      end
      if (acc > lim_pos) begin
         acc_cl = lim_pos;
      end
      p_mcand   = spc_pkg::INTEG_W'(err_now);
      drive_sum = drive_ff - spc_pkg::DRIVE_W'(i_prod);
      if (drive_sum[spc_pkg::DRIVE_W-1]) begin
         drive_sat = '0;
      end else if (drive_sum[spc_pkg::DRIVE_W-2:spc_pkg::WORD_W] != '0) begin
         drive_sat = '1;
      end else begin
         drive_sat = drive_sum[spc_pkg::WORD_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      setpoint_in  = setpoint_ff;
      speed_in     = speed_ff;
      integral_in  = integral_ff;
      stall_in     = stall_ff;
      err_in       = err_ff;
      drive_in     = drive_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_duty_in  = rsp_duty_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_error_in = rsp_error_ff;
      seen_clear   = 1'b0;
      div_start    = 1'b0;
      mul_start    = 1'b0;

      case (state_ff)
         spc_pkg::ST_IDLE: begin
            if (req_fire && req_ch.action) begin
               setpoint_in = req_ch.setpoint;
               seen_clear  = 1'b1;
               state_in    = spc_pkg::ST_ERR;
               if (!edge_seen) begin
                  stall_in = stall_inc;
                  if (stall_inc > stall_ticks_ff) begin
                     speed_in    = '0;
                     integral_in = '0;
                  end
               end else begin
                  stall_in = '0;
                  if (rev_period == '0) begin
                     speed_in    = '0;
                     integral_in = '0;
                  end else begin
                     div_start = 1'b1;
                     state_in  = spc_pkg::ST_DIV;
                  end
               end
            end
         end
         spc_pkg::ST_DIV: begin
            if (div_done) begin
               speed_in = (quotient[spc_pkg::WORD_W-1:spc_pkg::SPEED_W] != '0) ? '1
                                                      : quotient[spc_pkg::SPEED_W-1:0];
               state_in = spc_pkg::ST_ERR;
            end
         end
         spc_pkg::ST_ERR: begin
            err_in      = err_now;
            integral_in = acc_cl[spc_pkg::INTEG_W-1:0];
            mul_start   = 1'b1;
            state_in    = spc_pkg::ST_MUL;
         end
         spc_pkg::ST_MUL: begin
            if (p_done && i_done) begin
               state_in = spc_pkg::ST_SUM;
            end
         end
         spc_pkg::ST_SUM: begin
            drive_in = spc_pkg::DRIVE_W'(drive_offset_ff) - spc_pkg::DRIVE_W'(p_prod);
            state_in = spc_pkg::ST_FINAL;
         end
         spc_pkg::ST_FINAL: begin
            // hold here until the response register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = speed_ff;
               rsp_error_in = err_ff;
               if (setpoint_ff < min_setpoint_ff) begin
                  rsp_duty_in = '0;
                  integral_in = '0;
               end else begin
                  rsp_duty_in = drive_sat[spc_pkg::WORD_W-1:spc_pkg::WORD_W-spc_pkg::DUTY_W];
               end
               state_in = spc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= '0;
         integral_ff  <= '0;
         stall_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         speed_ff     <= speed_in;
         integral_ff  <= integral_in;
         stall_ff     <= stall_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      setpoint_ff  <= setpoint_in;
      err_ff       <= err_in;
      drive_ff     <= drive_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_error_ff <= rsp_error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_gain_ff           <= spc_pkg::RST_P_GAIN;
         i_gain_ff           <= spc_pkg::RST_I_GAIN;
         drive_offset_ff     <= spc_pkg::RST_DRIVE_OFFSET;
         integral_limit_ff   <= spc_pkg::RST_INTEGRAL_LIMIT;
         stall_ticks_ff      <= spc_pkg::RST_STALL_TICKS;
         min_setpoint_ff     <= spc_pkg::RST_MIN_SETPOINT;
         edges_per_sample_ff <= spc_pkg::RST_EDGES_PER_SAMPLE;
         rate_numerator_ff   <= spc_pkg::RST_RATE_NUMERATOR;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (spc_pkg::csr_index_type'(csr_ch.index))
            spc_pkg::CSR_P_GAIN:           p_gain_ff <= csr_ch.data[spc_pkg::GAIN_W-1:0];
            spc_pkg::CSR_I_GAIN:           i_gain_ff <= csr_ch.data[spc_pkg::GAIN_W-1:0];
            spc_pkg::CSR_DRIVE_OFFSET:     drive_offset_ff <= csr_ch.data;
            spc_pkg::CSR_INTEGRAL_LIMIT:
               integral_limit_ff <= csr_ch.data[spc_pkg::LIMIT_W-1:0];
            spc_pkg::CSR_STALL_TICKS:      stall_ticks_ff <= csr_ch.data[spc_pkg::STALL_W-1:0];
            spc_pkg::CSR_MIN_SETPOINT:     min_setpoint_ff <= csr_ch.data[spc_pkg::SETPT_W-1:0];
            spc_pkg::CSR_EDGES_PER_SAMPLE:
               edges_per_sample_ff <= csr_ch.data[spc_pkg::PHASE_W-1:0];
            spc_pkg::CSR_RATE_NUMERATOR:   rate_numerator_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.duty  = rsp_duty_ff;
   assign rsp_ch.speed = rsp_speed_ff;
   assign rsp_ch.error = rsp_error_ff;

endmodule
`default_nettype wire
